FILE: rtl/smx_pkg.sv
// Shared types, constants and exponential tables for the softmax block.
package smx_pkg;

    localparam int MaxLen = 16;
    localparam int IdxW = $clog2(MaxLen);
    localparam int CntW = $clog2(MaxLen + 1);
    localparam int SumW = 16 + CntW;
    localparam int NumW = 16 + 16 + 1;

    typedef struct packed {
        logic signed [15:0] score;
        logic               last_score;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] probability;
        logic [3:0]  position;
        logic        last_result;
        logic        overflow;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load;      // accept one input beat
        logic            clear;     // start a new vector
        logic            exp_rd;    // read score at idx
        logic            exp_wr;    // write exponential at idx, add to sum
        logic            div_rd;    // read exponential at idx
        logic            div_start; // start division on read data
        logic [IdxW-1:0] idx;
    } smx_cmd_t;

    typedef struct packed {
        logic [CntW-1:0] count;
        logic            div_done;
    } smx_sts_t;

    function automatic logic [16:0] eint(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0: v = 17'd65536;  5'd1: v = 17'd24109; 5'd2: v = 17'd8869;
            5'd3: v = 17'd3263;   5'd4: v = 17'd1200;  5'd5: v = 17'd442;
            5'd6: v = 17'd162;    5'd7: v = 17'd60;    5'd8: v = 17'd22;
            5'd9: v = 17'd8;      5'd10: v = 17'd3;    5'd11: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] fhi(input logic [3:0] j);
        logic [16:0] v;
        case (j)
            4'd0: v = 17'd65536;  4'd1: v = 17'd61565;  4'd2: v = 17'd57835;
            4'd3: v = 17'd54331;  4'd4: v = 17'd51039;  4'd5: v = 17'd47947;
            4'd6: v = 17'd45042;  4'd7: v = 17'd42313;  4'd8: v = 17'd39750;
            4'd9: v = 17'd37341;  4'd10: v = 17'd35079; 4'd11: v = 17'd32954;
            4'd12: v = 17'd30957; 4'd13: v = 17'd29081; 4'd14: v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] flo(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0: v = 17'd65536;  4'd1: v = 17'd65280;  4'd2: v = 17'd65026;
            4'd3: v = 17'd64772;  4'd4: v = 17'd64520;  4'd5: v = 17'd64268;
            4'd6: v = 17'd64018;  4'd7: v = 17'd63768;  4'd8: v = 17'd63520;
            4'd9: v = 17'd63272;  4'd10: v = 17'd63025; 4'd11: v = 17'd62780;
            4'd12: v = 17'd62535; 4'd13: v = 17'd62291; 4'd14: v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/smx_ram.sv
// Generic single-port-write, registered-read RAM.
module smx_ram #(
    parameter int Width = 16,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: rtl/smx_div.sv
// Restoring divider, one quotient bit per cycle, with rounding and saturation.
module smx_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [15:0]                   expval,
    input  logic [smx_pkg::SumW-1:0]      divisor,
    output logic                          done,
    output logic [15:0]                   quotient
);
    localparam int NW = smx_pkg::NumW;
    localparam int SW = smx_pkg::SumW;
    localparam int StepW = $clog2(NW + 1);

    logic [NW-1:0]   num_reg, num_next;
    logic [SW:0]     rem_reg, rem_next;
    logic [SW-1:0]   den_reg, den_next;
    logic [StepW-1:0] step_reg, step_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SW:0]     trial;
    logic [SW:0]     diff;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[SW-1:0], num_reg[NW-1]};
        diff      = trial - {1'b0, den_reg};
        if (start) begin
            num_next  = NW'({expval, 16'd0}) + NW'(divisor >> 1);
            rem_next  = '0;
            den_next  = divisor;
            step_next = StepW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next    = diff;
                num_next[0] = 1'b1;
            end else begin
                rem_next = trial;
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // Zero divisor gives zero, as an all-ones quotient would otherwise appear.
    assign done = done_reg;
    assign quotient = (den_reg == '0) ? 16'd0 :
                      (num_reg[NW-1:16] != '0) ? 16'hFFFF : num_reg[15:0];
endmodule

FILE: rtl/smx_datapath.sv
// Datapath: score and exponential buffers, maximum, exponential, sum, divider.
module smx_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  smx_pkg::smx_cmd_t    cmd,
    input  smx_pkg::in_beat_t    in_beat,
    output smx_pkg::smx_sts_t    sts,
    output logic                 overflow,
    output logic [15:0]          quotient
);
    localparam int CW = smx_pkg::CntW;
    localparam int IW = smx_pkg::IdxW;

    logic [CW-1:0]            count_reg, count_next;
    logic signed [15:0]       max_reg, max_next;
    logic [smx_pkg::SumW-1:0] sum_reg, sum_next;
    logic                     ovf_reg, ovf_next;
    logic                     store_en;
    logic [15:0]              score_rd, exp_rd_data;
    logic                     stage_reg;
    logic [16:0]              frac_reg;
    logic [4:0]               ip_reg;
    logic [33:0]              fprod;
    logic [16:0]              f;
    logic [33:0]              eprod;
    logic [17:0]              e_full;
    logic [15:0]              e_sat;
    logic signed [16:0]       d;
    logic [12:0]              n;

    assign store_en = cmd.load && (count_reg < CW'(smx_pkg::MaxLen));

    smx_ram #(.Width(16), .Depth(smx_pkg::MaxLen)) u_score_ram (
        .aclk(aclk), .wr_en(store_en), .wr_addr(count_reg[IW-1:0]),
        .wr_data(in_beat.score), .rd_addr(cmd.idx), .rd_data(score_rd)
    );

    smx_ram #(.Width(16), .Depth(smx_pkg::MaxLen)) u_exp_ram (
        .aclk(aclk), .wr_en(cmd.exp_wr), .wr_addr(cmd.idx),
        .wr_data(e_sat), .rd_addr(cmd.idx), .rd_data(exp_rd_data)
    );

    // Exponential stage one: clamp the difference and form the fraction product.
    always_comb begin
        d = 17'(max_reg) - 17'($signed(score_rd));
        if (d < 0) begin
            n = '0;
        end else if (d > 17'sd4096) begin
            n = 13'd4096;
        end else begin
            n = d[12:0];
        end
        fprod = smx_pkg::fhi(n[7:4]) * smx_pkg::flo(n[3:0]);
        f     = 17'((fprod + 34'd32768) >> 16);
    end

    always_ff @(posedge aclk) begin
        frac_reg <= f;
        ip_reg   <= n[12:8];
    end

    // Stage two: integer-part product with rounding and saturation.
    always_comb begin
        eprod  = smx_pkg::eint(ip_reg) * frac_reg;
        e_full = 18'((eprod + 34'd32768) >> 16);
        e_sat  = (e_full > 18'd65535) ? 16'hFFFF : e_full[15:0];
    end

    always_comb begin
        count_next = count_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        if (cmd.clear) begin
            count_next = '0;
            max_next   = 16'sh8000;
            sum_next   = '0;
            ovf_next   = 1'b0;
        end else if (cmd.load) begin
            if (store_en) begin
                count_next = count_reg + 1'b1;
                if (in_beat.score > max_reg) begin
                    max_next = in_beat.score;
                end
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.exp_wr) begin
            sum_next = sum_reg + smx_pkg::SumW'(e_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            max_reg   <= 16'sh8000;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            stage_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            stage_reg <= cmd.exp_rd;
        end
    end

    smx_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .expval(exp_rd_data), .divisor(sum_reg), .done(sts.div_done),
        .quotient(quotient)
    );

    assign sts.count = count_reg;
    assign overflow  = ovf_reg;

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) count_reg <= CW'(smx_pkg::MaxLen);
    endproperty
    assert property (p_count_bound) else $error("element count beyond buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (count_reg == '0) && (sum_reg == '0))
        else $error("clear did not reset vector state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && !store_en && !cmd.clear) |=> ovf_reg)
        else $error("dropped score did not flag overflow");

    // The exponential is written only after its score read has passed through stage_reg.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exp_wr |-> $past(stage_reg))
        else $error("exponential written without a pipelined read");
endmodule

FILE: rtl/smx_ctrl.sv
// Controller: sequences loading, exponential pass, division pass and output.
module smx_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_last,
    output logic [3:0]           m_position,
    output smx_pkg::smx_cmd_t    cmd,
    input  smx_pkg::smx_sts_t    sts
);
    localparam int IW = smx_pkg::IdxW;
    localparam int CW = smx_pkg::CntW;

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_ERD   = 7'b0000010,
        ST_EWAIT = 7'b0000100,
        ST_EWR   = 7'b0001000,
        ST_DRD   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          started_reg, started_next;

    assign s_ready    = (state_reg == ST_LOAD);
    assign m_valid    = (state_reg == ST_OUT);
    assign m_last     = (idx_reg + 1'b1 == sts.count);
    assign m_position = 4'(idx_reg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        started_next = 1'b0;
        cmd          = '0;
        cmd.idx      = idx_reg[IW-1:0];
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        idx_next   = '0;
                        state_next = ST_ERD;
                    end
                end
            end
            ST_ERD: begin
                // A vector with no stored scores (impossible) just ends here.
                if (sts.count == '0) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    cmd.exp_rd = 1'b1;
                    state_next = ST_EWAIT;
                end
            end
            ST_EWAIT: state_next = ST_EWR;
            ST_EWR: begin
                cmd.exp_wr = 1'b1;
                if (idx_reg + 1'b1 == sts.count) begin
                    idx_next   = '0;
                    state_next = ST_DRD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ERD;
                end
            end
            ST_DRD: begin
                cmd.div_rd   = 1'b1;
                started_next = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_start = started_reg;
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg + 1'b1 == sts.count) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DRD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            idx_reg     <= '0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            started_reg <= started_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg) &&
        !(s_ready && m_valid)) else $error("input and output open together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(idx_reg)))
        else $error("stalled result moved");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg < sts.count)) else $error("result index past count");
endmodule

FILE: rtl/softmax_vector.sv
// Top level of the max-subtracted fixed-point softmax block.
// Scores enter on the s_ channel as signed Q8.8, one beat each; s_data.last_score
// closes a vector. Up to 16 scores are buffered; extra scores are dropped and
// every result of that vector then carries overflow.
// After the closing beat, an exponential pass runs for each score: buffer read,
// table lookup and multiply, then second multiply and accumulate.
// A division pass follows: per score one buffer read, a restoring division
// (start, 33 quotient bits at one per cycle, completion) and one output beat
// on the m_ channel. The next score's division starts only once the previous
// result has been accepted.
// s_ready is high only while scores are being loaded; no new vector is taken
// until the last result of the current one has been accepted.
// When m_ready is low the current result is held unchanged on m_data.
// Reset (aresetn low at a clock edge) empties the buffer and returns to loading;
// no clearing pass is needed since stored entries are only read once written.
module softmax_vector (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smx_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smx_pkg::out_beat_t  m_data
);
    smx_pkg::smx_cmd_t cmd;
    smx_pkg::smx_sts_t sts;
    logic              ovf;
    logic [15:0]       quo;
    logic              last;
    logic [3:0]        pos;

    smx_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_last(s_data.last_score), .m_valid(m_valid), .m_ready(m_ready),
        .m_last(last), .m_position(pos), .cmd(cmd), .sts(sts)
    );

    smx_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_beat(s_data), .sts(sts),
        .overflow(ovf), .quotient(quo)
    );

    assign m_data.probability = quo;
    assign m_data.position    = pos;
    assign m_data.last_result = last;
    assign m_data.overflow    = ovf;
endmodule
